@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the permute address generator.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Checked on every rising clock edge outside of reset.
`define TPA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked on every rising clock edge, reset included.
`define TPA_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TPA_ASSERT(lbl, prop, msg)
`define TPA_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

@@ rtl/core/tpa_pkg.sv @@
// ----------------------------------------------------------------------------
// tpa_pkg
// Constants, register indexes and shared types of the permute address generator.
// ----------------------------------------------------------------------------
package tpa_pkg;

    localparam int DEF_MAX_RANK    = 6;
    localparam int DEF_AXIS_BITS   = 16;
    localparam int DEF_OFFSET_BITS = 32;

    localparam int CFG_INDEX_BITS     = 3;
    localparam int CFG_DATA_BITS      = 18;
    localparam int RANK_BITS          = 3;
    localparam int PERM_BITS          = 18;
    localparam int PERM_FIELD_BITS    = 3;
    localparam int PERM_EXT_BITS      = 24;
    localparam int SIZE_FIELD_BITS    = 16;
    localparam int NUM_SIZE_REGS      = 6;
    localparam int SOURCE_OFFSET_BITS = 32;

    localparam logic [CFG_INDEX_BITS-1:0] REG_TENSOR_RANK = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_PERM_ORDER  = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_AXIS_SIZE_0 = 3'd2;

    localparam logic [RANK_BITS-1:0] RANK_RESET = 3'd1;
    localparam logic [PERM_BITS-1:0] PERM_RESET = 18'd181896;

    typedef struct packed {
        logic busy;
        logic bad;
    } tpa_status_t;

endpackage

@@ rtl/core/tpa_step_if.sv @@
// ----------------------------------------------------------------------------
// tpa_step_if
// Step request channel: one beat asks for the next source offset.
// ----------------------------------------------------------------------------
interface tpa_step_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink (input valid, input restart, output ready);
endinterface

@@ rtl/core/tpa_result_if.sv @@
// ----------------------------------------------------------------------------
// tpa_result_if
// Result channel: one beat carries a source offset and its flags.
// ----------------------------------------------------------------------------
interface tpa_result_if import tpa_pkg::*; ;
    logic                          valid;
    logic                          ready;
    logic [SOURCE_OFFSET_BITS-1:0] source_offset;
    logic                          last_element;
    logic                          config_error;

    modport source (output valid, output source_offset, output last_element,
                    output config_error, input ready);
    modport sink (input valid, input source_offset, input last_element,
                  input config_error, output ready);
endinterface

@@ rtl/core/tensor_permute_address_gen.sv @@
// ----------------------------------------------------------------------------
// tensor_permute_address_gen
// Source-address generator for a tensor permute of up to MAX_RANK axes.
// ----------------------------------------------------------------------------
// Usage:
//   The cfg port writes rank, packed permutation and input axis sizes, one
//   register per cycle at cfg_we. Every write returns the walk to element 0.
//   Each beat on the step channel yields exactly one beat on the result
//   channel: the input linear offset of the next output element in row-major
//   output order, a last-element flag and a configuration error flag.
//   restart set on a step beat begins again at element 0 for that beat.
// Timing:
//   A result is registered and appears in the cycle after its step beat is
//   taken, and a step beat can be taken every cycle; the walk is one compare
//   chain and one add. After reset and after each register write a derivation
//   pass runs the stride, count and rewind products through two multipliers,
//   one for strides and count, one for rewinds; step.ready stays low meanwhile.
//   When the result receiver stalls, the result beat holds and step.ready
//   drops until the held beat is taken.
// ----------------------------------------------------------------------------
module tensor_permute_address_gen import tpa_pkg::*; #(
    parameter int MAX_RANK    = DEF_MAX_RANK,
    parameter int AXIS_BITS   = DEF_AXIS_BITS,
    parameter int OFFSET_BITS = DEF_OFFSET_BITS
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    tpa_step_if.sink                  step,
    tpa_result_if.source              result
);

    tpa_status_t                          status;
    logic [MAX_RANK-1:0]                  axis_used;
    logic [MAX_RANK-1:0][AXIS_BITS-1:0]   out_max;
    logic [MAX_RANK-1:0][OFFSET_BITS-1:0] delta;

    tpa_derive #(
        .MAX_RANK    (MAX_RANK),
        .AXIS_BITS   (AXIS_BITS),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_derive (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .status    (status),
        .axis_used (axis_used),
        .out_max   (out_max),
        .delta     (delta)
    );

    tpa_odometer #(
        .MAX_RANK    (MAX_RANK),
        .AXIS_BITS   (AXIS_BITS),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_odometer (
        .clk       (clk),
        .rst_n     (rst_n),
        .status    (status),
        .axis_used (axis_used),
        .out_max   (out_max),
        .delta     (delta),
        .step      (step),
        .result    (result)
    );

endmodule

@@ rtl/core/tpa_derive.sv @@
// ----------------------------------------------------------------------------
// tpa_derive
// Configuration registers and the sequencer that derives per-axis limits and
// offset steps from them after reset and after every register write.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tpa_derive import tpa_pkg::*; #(
    parameter int MAX_RANK    = DEF_MAX_RANK,
    parameter int AXIS_BITS   = DEF_AXIS_BITS,
    parameter int OFFSET_BITS = DEF_OFFSET_BITS
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [CFG_INDEX_BITS-1:0]             cfg_index,
    input  logic [CFG_DATA_BITS-1:0]              cfg_data,
    output tpa_status_t                           status,
    output logic [MAX_RANK-1:0]                   axis_used,
    output logic [MAX_RANK-1:0][AXIS_BITS-1:0]    out_max,
    output logic [MAX_RANK-1:0][OFFSET_BITS-1:0]  delta
);

    localparam int IDX_BITS  = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1;
    localparam int ACC_BITS  = OFFSET_BITS + 1;
    localparam int PROD_BITS = ACC_BITS + AXIS_BITS;
    localparam int BACK_BITS = AXIS_BITS + OFFSET_BITS;
    localparam logic [ACC_BITS-1:0] LIMIT = {1'b1, {OFFSET_BITS{1'b0}}};

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_STRIDE,
        S_PROD,
        S_ACCUM
    } state_t;

    state_t                               state_reg;
    logic [RANK_BITS-1:0]                 rank_reg;
    logic [PERM_BITS-1:0]                 perm_reg;
    logic [MAX_RANK-1:0][AXIS_BITS-1:0]   size_reg;
    logic [IDX_BITS-1:0]                  k_reg;
    logic [ACC_BITS-1:0]                  acc_reg;
    logic                                 bad_reg;
    logic [MAX_RANK-1:0][OFFSET_BITS-1:0] stride_reg;
    logic [OFFSET_BITS-1:0]               back_sum_reg;
    logic [OFFSET_BITS-1:0]               prod_reg;
    logic [MAX_RANK-1:0][AXIS_BITS-1:0]   out_max_reg;
    logic [MAX_RANK-1:0][OFFSET_BITS-1:0] delta_reg;

    logic                        wr_rank;
    logic                        wr_perm;
    logic                        wr_size;
    logic                        cfg_hit;
    logic [CFG_INDEX_BITS-1:0]   size_axis;
    logic [PERM_EXT_BITS-1:0]    perm_ext;
    logic [PERM_FIELD_BITS-1:0]  src [MAX_RANK];
    logic                        static_bad;
    logic [PERM_FIELD_BITS-1:0]  rd_src;
    logic [IDX_BITS-1:0]         rd_idx;
    logic [AXIS_BITS-1:0]        rd_size;
    logic [AXIS_BITS-1:0]        rd_size_m1;
    logic [OFFSET_BITS-1:0]      rd_stride;
    logic [PROD_BITS-1:0]        acc_prod;
    logic                        acc_ovf;
    logic [BACK_BITS-1:0]        back_prod;

    // Register write decode. A size write beyond the supported axes is dropped.
    always_comb
    begin
        size_axis = cfg_index - REG_AXIS_SIZE_0;
        wr_rank   = cfg_we && (cfg_index == REG_TENSOR_RANK);
        wr_perm   = cfg_we && (cfg_index == REG_PERM_ORDER);
        wr_size   = cfg_we && (cfg_index >= REG_AXIS_SIZE_0)
                    && (32'(cfg_index) < 32'(REG_AXIS_SIZE_0) + NUM_SIZE_REGS)
                    && (32'(size_axis) < MAX_RANK);
        cfg_hit   = wr_rank || wr_perm || wr_size;
    end

    // Checks that need no arithmetic: rank range, permutation and empty axes.
    always_comb
    begin
        logic rank_bad;
        logic perm_bad;
        logic zero_bad;
        perm_ext = PERM_EXT_BITS'(perm_reg);
        rank_bad = (rank_reg == '0) || (32'(rank_reg) > MAX_RANK);
        perm_bad = 1'b0;
        zero_bad = 1'b0;
        for (int a = 0; a < MAX_RANK; a++)
        begin
            src[a] = perm_ext[a*PERM_FIELD_BITS +: PERM_FIELD_BITS];
        end
        for (int a = 0; a < MAX_RANK; a++)
        begin
            if (a < 32'(rank_reg))
            begin
                if (src[a] >= rank_reg)
                begin
                    perm_bad = 1'b1;
                end
                if (size_reg[a] == '0)
                begin
                    zero_bad = 1'b1;
                end
                for (int b = a + 1; b < MAX_RANK; b++)
                begin
                    if ((b < 32'(rank_reg)) && (src[a] == src[b]))
                    begin
                        perm_bad = 1'b1;
                    end
                end
            end
        end
        static_bad = rank_bad || perm_bad || zero_bad;
    end

    // One read port on the size registers: the stride pass walks input axes,
    // the output pass walks the permuted ones.
    always_comb
    begin
        rd_src     = perm_ext[int'(k_reg)*PERM_FIELD_BITS +: PERM_FIELD_BITS];
        rd_idx     = (state_reg == S_STRIDE) ? k_reg : IDX_BITS'(rd_src);
        rd_size    = size_reg[rd_idx];
        rd_size_m1 = rd_size - AXIS_BITS'(1);
        rd_stride  = stride_reg[IDX_BITS'(rd_src)];
        acc_prod   = PROD_BITS'(acc_reg) * PROD_BITS'(rd_size);
        acc_ovf    = acc_prod > PROD_BITS'(LIMIT);
        back_prod  = BACK_BITS'(rd_size_m1) * BACK_BITS'(rd_stride);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_START;
            rank_reg  <= RANK_RESET;
            perm_reg  <= PERM_RESET;
            for (int a = 0; a < MAX_RANK; a++)
            begin
                size_reg[a] <= AXIS_BITS'(1);
            end
            k_reg     <= '0;
            bad_reg   <= 1'b0;
        end
        else
        begin
            if (wr_rank)
            begin
                rank_reg <= cfg_data[RANK_BITS-1:0];
            end
            if (wr_perm)
            begin
                perm_reg <= cfg_data[PERM_BITS-1:0];
            end
            for (int a = 0; a < MAX_RANK; a++)
            begin
                if (wr_size && (32'(size_axis) == a))
                begin
                    size_reg[a] <= AXIS_BITS'(cfg_data[SIZE_FIELD_BITS-1:0]);
                end
            end

            if (cfg_hit)
            begin
                state_reg <= S_START;
            end
            else
            begin
                case (state_reg)
                    S_IDLE:
                    begin
                        state_reg <= S_IDLE;
                    end
                    S_START:
                    begin
                        if (static_bad)
                        begin
                            bad_reg   <= 1'b1;
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            k_reg     <= IDX_BITS'(rank_reg - RANK_BITS'(1));
                            state_reg <= S_STRIDE;
                        end
                    end
                    S_STRIDE:
                    begin
                        // The stride of an axis is the product of all sizes inside it,
                        // so the running product doubles as the element count check.
                        if (acc_ovf)
                        begin
                            bad_reg   <= 1'b1;
                            state_reg <= S_IDLE;
                        end
                        else if (k_reg == '0)
                        begin
                            k_reg     <= IDX_BITS'(rank_reg - RANK_BITS'(1));
                            state_reg <= S_PROD;
                        end
                        else
                        begin
                            k_reg <= k_reg - IDX_BITS'(1);
                        end
                    end
                    S_PROD:
                    begin
                        state_reg <= S_ACCUM;
                    end
                    S_ACCUM:
                    begin
                        if (k_reg == '0)
                        begin
                            bad_reg   <= 1'b0;
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            k_reg     <= k_reg - IDX_BITS'(1);
                            state_reg <= S_PROD;
                        end
                    end
                    default:
                    begin
                        state_reg <= S_START;
                    end
                endcase
            end
        end
    end

    // Datapath registers of the derivation pass.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_START)
        begin
            acc_reg      <= ACC_BITS'(1);
            back_sum_reg <= '0;
        end
        if (state_reg == S_STRIDE)
        begin
            stride_reg[k_reg] <= OFFSET_BITS'(acc_reg);
            if (!acc_ovf)
            begin
                acc_reg <= ACC_BITS'(acc_prod);
            end
        end
        if (state_reg == S_PROD)
        begin
            // An increment of this axis rolls every inner axis back to zero,
            // which the accumulated rewind already covers.
            prod_reg           <= OFFSET_BITS'(back_prod);
            delta_reg[k_reg]   <= rd_stride - back_sum_reg;
            out_max_reg[k_reg] <= rd_size_m1;
        end
        if (state_reg == S_ACCUM)
        begin
            back_sum_reg <= back_sum_reg + prod_reg;
        end
    end

    always_comb
    begin
        status.busy = (state_reg != S_IDLE);
        status.bad  = bad_reg;
        for (int a = 0; a < MAX_RANK; a++)
        begin
            axis_used[a] = (a < 32'(rank_reg));
        end
    end

    assign out_max = out_max_reg;
    assign delta   = delta_reg;

    `TPA_ASSERT(a_acc_within_limit, (state_reg == S_STRIDE) |-> (acc_reg <= LIMIT), "running element count exceeded the limit")
    `TPA_ASSERT(a_write_restarts_pass, cfg_hit |=> (state_reg == S_START), "register write did not restart the derivation")
    `TPA_ASSERT(a_clean_pass_clears_bad, ((state_reg == S_ACCUM) && (k_reg == '0) && !cfg_hit) |=> (!bad_reg && (state_reg == S_IDLE)), "completed pass left the error flag set")

endmodule

@@ rtl/core/tpa_odometer.sv @@
// ----------------------------------------------------------------------------
// tpa_odometer
// Output coordinate counter and running source offset with a registered
// result beat.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tpa_odometer import tpa_pkg::*; #(
    parameter int MAX_RANK    = DEF_MAX_RANK,
    parameter int AXIS_BITS   = DEF_AXIS_BITS,
    parameter int OFFSET_BITS = DEF_OFFSET_BITS
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  tpa_status_t                           status,
    input  logic [MAX_RANK-1:0]                   axis_used,
    input  logic [MAX_RANK-1:0][AXIS_BITS-1:0]    out_max,
    input  logic [MAX_RANK-1:0][OFFSET_BITS-1:0]  delta,
    tpa_step_if.sink                              step,
    tpa_result_if.source                          result
);

    logic [MAX_RANK-1:0][AXIS_BITS-1:0] coord_reg;
    logic [OFFSET_BITS-1:0]             offset_reg;
    logic                               out_valid_reg;
    logic [SOURCE_OFFSET_BITS-1:0]      res_offset_reg;
    logic                               res_last_reg;
    logic                               res_err_reg;

    logic                               in_ready;
    logic                               accept;
    logic [MAX_RANK-1:0][AXIS_BITS-1:0] cur_coord;
    logic [OFFSET_BITS-1:0]             cur_offset;
    logic [MAX_RANK-1:0]                at_max;
    logic [MAX_RANK-1:0]                carry;
    logic                               last_now;
    logic [OFFSET_BITS-1:0]             step_delta;
    logic [MAX_RANK-1:0][AXIS_BITS-1:0] coord_next;
    logic [OFFSET_BITS-1:0]             offset_next;

    assign in_ready = !status.busy && (!out_valid_reg || result.ready);
    assign accept   = step.valid && in_ready;

    // The innermost axis that is not at its last index increments; every axis
    // inside it wraps to zero. Unused axes always count as wrapped.
    always_comb
    begin
        logic c;
        cur_offset = step.restart ? '0 : offset_reg;
        for (int a = 0; a < MAX_RANK; a++)
        begin
            cur_coord[a] = step.restart ? '0 : coord_reg[a];
            at_max[a]    = !axis_used[a] || (cur_coord[a] == out_max[a]);
        end
        c = 1'b1;
        for (int a = MAX_RANK - 1; a >= 0; a--)
        begin
            carry[a] = c;
            c        = c && at_max[a];
        end
        last_now   = c;
        step_delta = '0;
        for (int a = 0; a < MAX_RANK; a++)
        begin
            if (carry[a] && !at_max[a])
            begin
                step_delta = step_delta | delta[a];
            end
            if (status.bad || last_now || (carry[a] && at_max[a]))
            begin
                coord_next[a] = '0;
            end
            else if (carry[a])
            begin
                coord_next[a] = cur_coord[a] + AXIS_BITS'(1);
            end
            else
            begin
                coord_next[a] = cur_coord[a];
            end
        end
        offset_next = (status.bad || last_now) ? '0 : (cur_offset + step_delta);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coord_reg     <= '0;
            offset_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (status.busy)
            begin
                coord_reg  <= '0;
                offset_reg <= '0;
            end
            else if (accept)
            begin
                coord_reg  <= coord_next;
                offset_reg <= offset_next;
            end
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_offset_reg <= status.bad ? '0 : SOURCE_OFFSET_BITS'(cur_offset);
            res_last_reg   <= status.bad || last_now;
            res_err_reg    <= status.bad;
        end
    end

    assign step.ready           = in_ready;
    assign result.valid         = out_valid_reg;
    assign result.source_offset = res_offset_reg;
    assign result.last_element  = res_last_reg;
    assign result.config_error  = res_err_reg;

    `TPA_ASSERT_ALWAYS(a_error_beat_form, (out_valid_reg && res_err_reg) |-> ((res_offset_reg == '0) && res_last_reg), "error beat must carry offset zero and the last flag")
    `TPA_ASSERT(a_wrap_after_last, (accept && !status.bad && last_now) |=> ((offset_reg == '0) && (coord_reg == '0)), "position did not wrap after the last element")
    `TPA_ASSERT(a_accept_gives_beat, accept |=> out_valid_reg, "accepted step produced no result beat")

endmodule

@@ sim/tpa_offset_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpa_offset_checker
// Watches the register port and both channels of the permute address
// generator, predicts the source offset and flags of every result beat, and
// compares each result beat against the oldest prediction in order.
// ----------------------------------------------------------------------------
module tpa_offset_checker
    import tpa_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    tpa_step_if                       step_mon,
    tpa_result_if                     result_mon,
    output int                        mismatches,
    output int                        awaiting
);

    localparam int AXES   = DEF_MAX_RANK;
    localparam int AXIS_W = DEF_AXIS_BITS;
    localparam int OFF_W  = DEF_OFFSET_BITS;

    typedef struct packed {
        logic [SOURCE_OFFSET_BITS-1:0] offset;
        logic                          last;
        logic                          cfg_err;
    } walk_result_t;

    // Register copies.
    logic [RANK_BITS-1:0]       rank_q;
    logic [PERM_BITS-1:0]       perm_q;
    logic [AXIS_W-1:0]          size_q [AXES];

    // Geometry derived from the registers.
    logic [PERM_FIELD_BITS-1:0] src_axis [AXES];
    logic [AXIS_W-1:0]          dim [AXES];
    logic [OFF_W-1:0]           stride [AXES];
    logic                       geom_bad;

    // Position of the walk over the output tensor.
    logic [AXIS_W-1:0]          coord [AXES];
    logic [OFF_W-1:0]           walk_offset;

    walk_result_t               pending_offsets [$];

    function automatic void rewind_walk();
        int i;
        for (i = 0; i < AXES; i++)
            coord[i] = '0;
        walk_offset = '0;
    endfunction

    function automatic void derive_geometry();
        int          r;
        int          i;
        logic [7:0]  seen;
        logic [63:0] count;
        r = rank_q;
        geom_bad = (r == 0 || r > AXES);
        for (i = 0; i < AXES; i++)
        begin
            src_axis[i] = perm_q[PERM_FIELD_BITS*i +: PERM_FIELD_BITS];
            stride[i]   = 1;
            dim[i]      = 1;
        end
        if (geom_bad)
            return;
        seen = '0;
        for (i = 0; i < r; i++)
        begin
            if (src_axis[i] >= r || seen[src_axis[i]])
            begin
                geom_bad = 1'b1;
                return;
            end
            seen[src_axis[i]] = 1'b1;
        end
        // The element count may reach 2^OFFSET_BITS exactly but not pass it.
        count = 1;
        for (i = 0; i < r; i++)
        begin
            if (size_q[i] == 0 || count * size_q[i] > (64'd1 << OFF_W))
            begin
                geom_bad = 1'b1;
                return;
            end
            count = count * size_q[i];
        end
        for (i = r - 1; i > 0; i--)
            stride[i-1] = stride[i] * size_q[i];
        for (i = 0; i < r; i++)
            dim[i] = size_q[src_axis[i]];
    endfunction

    function automatic void apply_cfg_write(input logic [CFG_INDEX_BITS-1:0] idx,
                                            input logic [CFG_DATA_BITS-1:0] data);
        if (idx == REG_TENSOR_RANK)
            rank_q = data[RANK_BITS-1:0];
        else if (idx == REG_PERM_ORDER)
            perm_q = data[PERM_BITS-1:0];
        else
            size_q[idx - REG_AXIS_SIZE_0] = data[AXIS_W-1:0];
        rewind_walk();
        derive_geometry();
    endfunction

    function automatic walk_result_t next_source(input logic restart);
        walk_result_t     res;
        logic             at_end;
        logic [OFF_W-1:0] st;
        int               r;
        int               a;
        r = rank_q;
        if (restart)
            rewind_walk();
        if (geom_bad)
        begin
            rewind_walk();
            res.offset  = '0;
            res.last    = 1'b1;
            res.cfg_err = 1'b1;
            return res;
        end
        res.offset  = walk_offset;
        res.cfg_err = 1'b0;
        at_end = 1'b1;
        for (a = 0; a < r; a++)
            if (coord[a] != dim[a] - 16'd1)
                at_end = 1'b0;
        res.last = at_end;
        if (at_end)
        begin
            rewind_walk();
            return res;
        end
        // Odometer step: innermost output axis first, carrying outward.
        for (a = r - 1; a >= 0; a--)
        begin
            st = stride[src_axis[a]];
            coord[a] = coord[a] + 16'd1;
            walk_offset = walk_offset + st;
            if (coord[a] < dim[a])
                break;
            coord[a] = '0;
            walk_offset = walk_offset - dim[a] * st;
        end
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        walk_result_t want;
        walk_result_t got;
        logic         bad;
        int           i;
        if (!rst_n)
        begin
            rank_q = RANK_RESET;
            perm_q = PERM_RESET;
            for (i = 0; i < AXES; i++)
                size_q[i] = 1;
            rewind_walk();
            derive_geometry();
            pending_offsets.delete();
            mismatches <= 0;
            awaiting   <= 0;
        end
        else
        begin
            if (cfg_we)
                apply_cfg_write(cfg_index, cfg_data);
            // Compare before queueing, so a stray beat never meets a fresh prediction.
            if (result_mon.valid && result_mon.ready)
            begin
                got = {result_mon.source_offset, result_mon.last_element,
                       result_mon.config_error};
                if (pending_offsets.size() == 0)
                begin
                    $display("%0t: result beat with nothing expected: offset %h last %b error %b",
                             $time, got.offset, got.last, got.cfg_err);
                    mismatches <= mismatches + 1;
                end
                else
                begin
                    want = pending_offsets.pop_front();
                    bad = 1'b0;
                    if (got.offset !== want.offset)
                    begin
                        $display("%0t: source_offset expected %h actual %h",
                                 $time, want.offset, got.offset);
                        bad = 1'b1;
                    end
                    if (got.last !== want.last)
                    begin
                        $display("%0t: last_element expected %b actual %b",
                                 $time, want.last, got.last);
                        bad = 1'b1;
                    end
                    if (got.cfg_err !== want.cfg_err)
                    begin
                        $display("%0t: config_error expected %b actual %b",
                                 $time, want.cfg_err, got.cfg_err);
                        bad = 1'b1;
                    end
                    if (bad)
                        mismatches <= mismatches + 1;
                end
            end
            if (step_mon.valid && step_mon.ready)
                pending_offsets.push_back(next_source(step_mon.restart));
            awaiting <= pending_offsets.size();
        end
    end

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives register settings and step beats into the permute address generator
// with random pacing on both channels, first a directed walk through the
// extremes and error cases, then random tensor shapes, and reports the verdict.
// ----------------------------------------------------------------------------
module tb import tpa_pkg::*; ;

    localparam int ITEM_GOAL     = 800;
    localparam int SETTLE_CYCLES = 25;
    localparam int NUM_REGS      = 2 + NUM_SIZE_REGS;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      cfg_we;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;
    int                        mismatches;
    int                        awaiting;
    bit                        steady;

    // Register values to be loaded in the next setting.
    logic [CFG_DATA_BITS-1:0]  rank_word;
    logic [CFG_DATA_BITS-1:0]  perm_word;
    logic [CFG_DATA_BITS-1:0]  size_word [NUM_SIZE_REGS];

    tpa_step_if   step_ch ();
    tpa_result_if result_ch ();

    tensor_permute_address_gen i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .step      (step_ch),
        .result    (result_ch)
    );

    tpa_offset_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .step_mon   (step_ch),
        .result_mon (result_ch),
        .mismatches (mismatches),
        .awaiting   (awaiting)
    );

    always
    begin
        #2;
        clk = 1'b1;
        #2;
        clk = 1'b0;
    end

    initial
    begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int gap_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (steady || roll < 55)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    function automatic logic [CFG_DATA_BITS-1:0] perm_of(input int f0, input int f1,
                                                          input int f2, input int f3,
                                                          input int f4, input int f5);
        return {3'(f5), 3'(f4), 3'(f3), 3'(f2), 3'(f1), 3'(f0)};
    endfunction

    function automatic void set_geometry(input int r, input int s0, input int s1,
                                         input int s2, input int s3, input int s4,
                                         input int s5);
        rank_word    = CFG_DATA_BITS'(r);
        size_word[0] = CFG_DATA_BITS'(s0);
        size_word[1] = CFG_DATA_BITS'(s1);
        size_word[2] = CFG_DATA_BITS'(s2);
        size_word[3] = CFG_DATA_BITS'(s3);
        size_word[4] = CFG_DATA_BITS'(s4);
        size_word[5] = CFG_DATA_BITS'(s5);
    endfunction

    // A legal shape: a true permutation of the first r axes, junk above the rank
    // and in unused data bits. Sizes stay small so walks wrap often, unless big.
    function automatic void shape_valid(input int r, input bit big);
        int ax [NUM_SIZE_REGS];
        int j;
        int k;
        int t;
        int smax;
        for (j = 0; j < NUM_SIZE_REGS; j++)
            ax[j] = j;
        for (j = r - 1; j > 0; j--)
        begin
            k = $urandom_range(0, j);
            t = ax[j];
            ax[j] = ax[k];
            ax[k] = t;
        end
        for (j = r; j < NUM_SIZE_REGS; j++)
            ax[j] = $urandom_range(0, 7);
        for (j = 0; j < NUM_SIZE_REGS; j++)
            perm_word[PERM_FIELD_BITS*j +: PERM_FIELD_BITS] = PERM_FIELD_BITS'(ax[j]);
        rank_word = {(CFG_DATA_BITS-RANK_BITS)'($urandom), RANK_BITS'(r)};
        smax = (r <= 2) ? 8 : (r <= 4) ? 3 : 2;
        for (j = 0; j < NUM_SIZE_REGS; j++)
            size_word[j] = {2'($urandom),
                            (j < r) ? 16'($urandom_range(1, smax)) : 16'($urandom)};
        if (big)
            size_word[$urandom_range(0, r - 1)][15:0] =
                $urandom_range(0, 1) ? 16'hFFFF : 16'($urandom_range(256, 65535));
    endfunction

    function automatic void shape_broken(input int r);
        int j;
        int k;
        case ($urandom_range(0, 5))
            0: rank_word[RANK_BITS-1:0] = $urandom_range(0, 1) ? 3'd0 : 3'd7;
            1:
            begin
                if (r < 2)
                begin
                    r = 2;
                    shape_valid(r, 1'b0);
                end
                j = $urandom_range(1, r - 1);
                k = $urandom_range(0, j - 1);
                perm_word[PERM_FIELD_BITS*j +: PERM_FIELD_BITS] =
                    perm_word[PERM_FIELD_BITS*k +: PERM_FIELD_BITS];
            end
            2:
            begin
                if (r == NUM_SIZE_REGS)
                begin
                    r = NUM_SIZE_REGS - 1;
                    shape_valid(r, 1'b0);
                end
                j = $urandom_range(0, r - 1);
                perm_word[PERM_FIELD_BITS*j +: PERM_FIELD_BITS] =
                    PERM_FIELD_BITS'($urandom_range(r, 7));
            end
            3: size_word[$urandom_range(0, r - 1)][15:0] = '0;
            4:
            begin
                if (r < 3)
                begin
                    r = 3;
                    shape_valid(r, 1'b0);
                end
                for (j = 0; j < 3; j++)
                    size_word[j][15:0] = 16'hFFFF;
            end
            default:
            begin
                rank_word = CFG_DATA_BITS'($urandom);
                perm_word = CFG_DATA_BITS'($urandom);
                for (j = 0; j < NUM_SIZE_REGS; j++)
                    size_word[j] = $urandom_range(0, 3) == 0 ? '0 : CFG_DATA_BITS'($urandom);
            end
        endcase
    endfunction

    function automatic longint unsigned element_total();
        longint unsigned p;
        int              j;
        int              r;
        r = rank_word[RANK_BITS-1:0];
        if (r == 0 || r > NUM_SIZE_REGS)
            return 0;
        p = 1;
        for (j = 0; j < r; j++)
            p = p * size_word[j][15:0];
        return p;
    endfunction

    task automatic settle();
        do
            @(posedge clk);
        while (awaiting != 0);
    endtask

    task automatic write_reg(input int which);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_INDEX_BITS'(which);
        if (which == REG_TENSOR_RANK)
            cfg_data <= rank_word;
        else if (which == REG_PERM_ORDER)
            cfg_data <= perm_word;
        else
            cfg_data <= size_word[which - REG_AXIS_SIZE_0];
        @(posedge clk);
    endtask

    // Registers change only with no result outstanding; the order is shuffled.
    task automatic load_config(input bit every);
        int order [NUM_REGS];
        int j;
        int k;
        int t;
        step_ch.valid <= 1'b0;
        settle();
        for (j = 0; j < NUM_REGS; j++)
            order[j] = j;
        for (j = NUM_REGS - 1; j > 0; j--)
        begin
            k = $urandom_range(0, j);
            t = order[j];
            order[j] = order[k];
            order[k] = t;
        end
        for (j = 0; j < NUM_REGS; j++)
            if (every || $urandom_range(0, 1) == 1)
                write_reg(order[j]);
        cfg_we <= 1'b0;
    endtask

    task automatic send_step(input logic rs);
        int gap;
        step_ch.valid   <= 1'b1;
        step_ch.restart <= rs;
        do
            @(posedge clk);
        while (!step_ch.ready);
        gap = gap_len();
        if (gap != 0)
        begin
            step_ch.valid   <= 1'b0;
            step_ch.restart <= 1'($urandom_range(0, 1));
            repeat (gap) @(posedge clk);
        end
    endtask

    initial
    begin : result_pacing
        int stall;
        result_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            result_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 16)) @(posedge clk);
            stall = gap_len();
            if (stall != 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
        end
    end

    initial
    begin : stimulus
        int              n;
        int              sent;
        int              kind;
        int              r;
        longint unsigned total;
        step_ch.valid   = 1'b0;
        step_ch.restart = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = REG_TENSOR_RANK;
        cfg_data        = '0;
        steady          = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Reset shape is a single element: every beat is the last one.
        send_step(1'b0);
        send_step(1'b1);

        // 2x3 transpose through a full wrap, then a restart mid-walk.
        set_geometry(2, 2, 3, 1, 1, 1, 1);
        perm_word = perm_of(1, 0, 7, 7, 7, 7);
        load_config(1'b1);
        repeat (8) send_step(1'b0);
        send_step(1'b1);

        // Largest legal axes; one unused size register gets all data bits set.
        set_geometry(2, 65535, 65535, 1, 1, 1, 262143);
        load_config(1'b1);
        repeat (3) send_step(1'b0);

        // Unusable settings: rank zero, rank above the limit, repeated axis,
        // axis beyond the rank, empty axis, too many elements.
        set_geometry(0, 2, 2, 2, 2, 2, 2);
        perm_word = PERM_RESET;
        load_config(1'b1);
        send_step(1'b0);
        set_geometry(7, 2, 2, 2, 2, 2, 2);
        load_config(1'b1);
        send_step(1'b0);
        set_geometry(3, 2, 2, 2, 1, 1, 1);
        perm_word = perm_of(0, 0, 1, 3, 4, 5);
        load_config(1'b1);
        send_step(1'b0);
        set_geometry(2, 2, 2, 1, 1, 1, 1);
        perm_word = perm_of(0, 5, 2, 3, 4, 5);
        load_config(1'b1);
        send_step(1'b0);
        set_geometry(2, 3, 0, 1, 1, 1, 1);
        perm_word = PERM_RESET;
        load_config(1'b1);
        send_step(1'b0);
        set_geometry(3, 65535, 65535, 65535, 1, 1, 1);
        load_config(1'b1);
        send_step(1'b0);

        // Exactly 2^32 elements is still legal.
        set_geometry(4, 256, 256, 256, 256, 1, 1);
        perm_word = perm_of(3, 2, 1, 0, 4, 5);
        load_config(1'b1);
        repeat (2) send_step(1'b0);

        // Full rank, fully reversed.
        set_geometry(6, 2, 2, 2, 2, 2, 2);
        perm_word = perm_of(5, 4, 3, 2, 1, 0);
        load_config(1'b1);
        repeat (3) send_step(1'b0);

        sent = 0;
        while (sent < ITEM_GOAL)
        begin
            kind   = $urandom_range(0, 99);
            r      = $urandom_range(1, 6);
            steady = ($urandom_range(0, 4) == 0);
            shape_valid(r, kind < 10);
            if (kind >= 88)
                shape_broken(r);
            load_config(kind < 88 || $urandom_range(0, 1) == 1);
            total = element_total();
            if (kind >= 88 || total == 0)
                n = $urandom_range(1, 6);
            else if (total <= 40)
                n = int'(total) * $urandom_range(1, 3) + $urandom_range(0, 3);
            else
                n = $urandom_range(5, 40);
            repeat (n)
            begin
                send_step($urandom_range(0, 24) == 0);
                // Now and then hold off until every result is back.
                if ($urandom_range(0, 39) == 0)
                begin
                    step_ch.valid <= 1'b0;
                    settle();
                end
            end
            sent += n;
        end

        steady = 1'b0;
        step_ch.valid <= 1'b0;
        settle();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && awaiting == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/tpa_pkg.sv
rtl/core/tpa_step_if.sv
rtl/core/tpa_result_if.sv
rtl/core/tpa_derive.sv
rtl/core/tpa_odometer.sv
rtl/core/tensor_permute_address_gen.sv
sim/tpa_offset_checker.sv
sim/tb.sv
